[sv/dih_pkg.sv]
`default_nettype none
package dih_pkg;
   localparam int INDEX_BITS = 10;
   localparam int WAYS = 4;
   localparam int SHIFT_STEP = 16;
   localparam int NUM_BUCKETS = 1 << INDEX_BITS;
   localparam int FILL_BITS = $clog2(WAYS + 1);
   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SLOT_BITS = 64 + 64 + 16;
   localparam logic OP_SEARCH = 1'b0;
   localparam logic OP_ADD = 1'b1;
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_FULL = 1'b1;
   typedef logic [INDEX_BITS-1:0] bucket_type;
   typedef logic [FILL_BITS-1:0] fill_type;

   function automatic bucket_type bucket_of(input logic [63:0] dev, input logic [63:0] ino);
      logic [63:0] h;
      h = dev ^ ino ^ (ino >> SHIFT_STEP) ^ (ino >> (2 * SHIFT_STEP))
         ^ (ino >> (3 * SHIFT_STEP));
      return h[INDEX_BITS-1:0];
   endfunction
endpackage
`default_nettype wire

[sv/device_inode_hash_table_unit.sv]
`default_nettype none
// device/inode hash table: each item (search or add) takes a bucket read of all ways from
// synchronous memory, then compare and write-back, so items are handled one at a time
// (accept, memory read, result registered); a new item is accepted only after the result
// has been taken via rsp_ready. after reset a clearing pass zeroes the bucket fill memory,
// one bucket a cycle, during which no item is accepted. slot contents are not cleared.
module device_inode_hash_table_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [63:0] req_device_number,
   input  wire logic [63:0] req_inode_number,
   input  wire logic [15:0] req_name_handle,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_found,
   output logic [15:0]      rsp_match_handle,
   output logic             rsp_status
);
   import dih_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   logic [1:0] state_ff, state_in;
   bucket_type clr_ff, clr_in;

   // one row per bucket: every way side by side, plus fill count memory
   logic [SLOT_BITS-1:0] slot_mem [NUM_BUCKETS][WAYS];
   fill_type fill_mem [NUM_BUCKETS];
   logic [SLOT_BITS-1:0] row_rd_ff [WAYS];
   fill_type fill_rd_ff;

   // captured item
   logic op_ff;
   logic [63:0] dev_ff, ino_ff;
   logic [15:0] hdl_ff;
   bucket_type bkt_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic found_ff, status_ff;
   logic [15:0] match_ff;

   wire logic accept = req_valid && req_ready;
   bucket_type req_bucket;
   assign req_bucket = bucket_of(req_device_number, req_inode_number);
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   // compare over the ways, newest match wins
   logic hit;
   logic [15:0] hit_hdl;
   logic full;
   logic fill_we;
   always_comb begin
      hit = 1'b0;
      hit_hdl = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (FILL_BITS'(w) < fill_rd_ff
             && row_rd_ff[w][SLOT_BITS-1 -: 64] == dev_ff
             && row_rd_ff[w][79:16] == ino_ff) begin
            hit = 1'b1;
            hit_hdl = row_rd_ff[w][15:0];
         end
      end
      full = fill_rd_ff >= FILL_BITS'(WAYS);
      fill_we = (state_ff == ST_READ) && op_ff == OP_ADD && !full;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == bucket_type'(NUM_BUCKETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: begin
            state_in = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // memory ports: read at accept, write back in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int w = 0; w < WAYS; w++) row_rd_ff[w] <= slot_mem[req_bucket][w];
         fill_rd_ff <= fill_mem[req_bucket];
      end
      if (state_ff == ST_CLEAR) fill_mem[clr_ff] <= '0;
      else if (fill_we) fill_mem[bkt_ff] <= fill_rd_ff + 1'b1;
      if (fill_we) slot_mem[bkt_ff][fill_rd_ff[WAY_BITS-1:0]] <= {dev_ff, ino_ff, hdl_ff};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_opcode;
         dev_ff <= req_device_number;
         ino_ff <= req_inode_number;
         hdl_ff <= req_name_handle;
         bkt_ff <= req_bucket;
      end
      if (state_ff == ST_READ) begin
         found_ff <= (op_ff == OP_SEARCH) && hit;
         match_ff <= (op_ff == OP_SEARCH) ? hit_hdl : 16'd0;
         status_ff <= (op_ff == OP_ADD && full) ? STATUS_FULL : STATUS_OK;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = found_ff;
   assign rsp_match_handle = match_ff;
   assign rsp_status = status_ff;
endmodule
`default_nettype wire

[sv/dih_checker.sv]
`default_nettype none
module dih_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_opcode,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_found,
   input wire logic [15:0] rsp_match_handle,
   input wire logic        rsp_status
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_handle))
      else $error("result dropped while stalled");
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_add_nofound: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode |-> ##2 (rsp_valid && !rsp_found))
      else $error("add reported found");
   a_full_nomatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_found && rsp_match_handle == 16'd0)
      else $error("full with match");
endmodule

bind device_inode_hash_table_unit dih_checker u_dih_checker (.*);
`default_nettype wire
